@@ rtl/msplit_pkg.sv @@
// Package for the mapping range page splitter.
// Holds the request and result item types, status and page size codes.
// No dependencies.
package msplit_pkg;

    localparam int ADDR_W  = 64;
    localparam int COUNT_W = 52;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISALIGN = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;

    localparam logic [1:0] PS_4K = 2'd0;
    localparam logic [1:0] PS_2M = 2'd1;
    localparam logic [1:0] PS_1G = 2'd2;

    // Offset bits inside a page of each size
    localparam int SH_4K = 12;
    localparam int SH_2M = 21;
    localparam int SH_1G = 30;

    typedef struct packed {
        logic [ADDR_W-1:0] virtual_base;
        logic [ADDR_W-1:0] physical_base;
        logic [ADDR_W-1:0] range_length;
    } t_req_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  segment_virtual;
        logic [ADDR_W-1:0]  segment_physical;
        logic [1:0]         page_size_code;
        logic [COUNT_W-1:0] page_count;
        logic [1:0]         status;
        logic               last_segment;
    } t_seg_item;

    // Classified request as held between front and back
    typedef struct packed {
        t_req_item  req;
        logic [1:0] status;
    } t_req_entry;

endpackage

@@ rtl/msplit_front.sv @@
// Front end: checks alignment of a request and tags it with its status.
// Depends on msplit_pkg.
module msplit_front (
    input  msplit_pkg::t_req_item  i_item,
    output msplit_pkg::t_req_entry o_entry
);
    import msplit_pkg::*;

    logic base_bad;
    logic len_bad;

    assign base_bad = (i_item.virtual_base[SH_4K-1:0] != '0)
                   || (i_item.physical_base[SH_4K-1:0] != '0);
    assign len_bad  = (i_item.range_length[SH_4K-1:0] != '0);

    always_comb begin
        o_entry.req = i_item;
        if (base_bad) begin
            o_entry.status = ST_MISALIGN;
        end else if (len_bad) begin
            o_entry.status = ST_BAD_LEN;
        end else begin
            o_entry.status = ST_OK;
        end
    end

endmodule

@@ rtl/msplit_fifo.sv @@
// Small synchronous queue of items of any packed type.
// No package dependency. DEPTH must be at least 2.
module msplit_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output T     o_data
);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 r_mem [DEPTH];
    logic [IDX_W-1:0] r_wr, n_wr;
    logic [IDX_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wr = (r_wr == IDX_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == IDX_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/msplit_back.sv @@
// Back end: walks one classified request; emits one segment per cycle while
// i_seg_full is low. Depends on msplit_pkg.
module msplit_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_empty,
    input  msplit_pkg::t_req_entry i_req,
    output logic                   o_req_pop,
    input  logic                   i_seg_full,
    output logic                   o_seg_push,
    output msplit_pkg::t_seg_item  o_seg
);
    import msplit_pkg::*;

    logic              r_busy, n_busy;
    logic [ADDR_W-1:0] r_va, n_va;
    logic [ADDR_W-1:0] r_pa, n_pa;
    logic [ADDR_W-1:0] r_rem, n_rem;
    logic [1:0]        r_status, n_status;

    logic [ADDR_W-1:0] both;
    logic              use_1g;
    logic              use_2m;
    logic [ADDR_W-1:0] len;
    logic [ADDR_W-1:0] rest;
    logic [1:0]        code;
    logic [COUNT_W-1:0] count;
    logic              seg_last;
    logic              done;

    assign both   = r_va | r_pa;
    assign use_1g = (both[SH_1G-1:0] == '0) && (r_rem[ADDR_W-1:SH_1G] != '0);
    assign use_2m = (both[SH_2M-1:0] == '0) && (r_rem[ADDR_W-1:SH_2M] != '0);

    // Whole pages of the chosen size; what is left goes to the next segment
    always_comb begin
        if (use_1g) begin
            code  = PS_1G;
            count = COUNT_W'(r_rem[ADDR_W-1:SH_1G]);
            len   = {r_rem[ADDR_W-1:SH_1G], {SH_1G{1'b0}}};
        end else if (use_2m) begin
            code  = PS_2M;
            count = COUNT_W'(r_rem[ADDR_W-1:SH_2M]);
            len   = {r_rem[ADDR_W-1:SH_2M], {SH_2M{1'b0}}};
        end else begin
            code  = PS_4K;
            count = r_rem[ADDR_W-1:SH_4K];
            len   = r_rem;
        end
        rest = r_rem ^ len;
    end

    // Error results are single and carry no pages
    assign seg_last = (r_status != ST_OK) || (rest == '0);

    always_comb begin
        o_seg.segment_virtual  = r_va;
        o_seg.segment_physical = r_pa;
        o_seg.status           = r_status;
        o_seg.last_segment     = seg_last;
        if (r_status != ST_OK) begin
            o_seg.page_size_code = PS_4K;
            o_seg.page_count     = '0;
        end else begin
            o_seg.page_size_code = code;
            o_seg.page_count     = count;
        end
    end

    assign o_seg_push = r_busy && !i_seg_full;
    assign done       = o_seg_push && seg_last;
    assign o_req_pop  = !i_req_empty && (!r_busy || done);

    always_comb begin
        n_busy   = r_busy;
        n_va     = r_va;
        n_pa     = r_pa;
        n_rem    = r_rem;
        n_status = r_status;
        if (o_req_pop) begin
            n_busy   = 1'b1;
            n_va     = i_req.req.virtual_base;
            n_pa     = i_req.req.physical_base;
            n_rem    = i_req.req.range_length;
            n_status = i_req.status;
        end else if (done) begin
            n_busy = 1'b0;
        end else if (o_seg_push) begin
            n_va  = r_va + len;
            n_pa  = r_pa + len;
            n_rem = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_va     <= n_va;
        r_pa     <= n_pa;
        r_rem    <= n_rem;
        r_status <= n_status;
    end

endmodule

@@ rtl/mapping_range_page_splitter.sv @@
// Top level of the mapping range page splitter.
// Depends on msplit_pkg, msplit_front, msplit_fifo, msplit_back.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------
//  request   | push / full          | i_item   (msplit_pkg::t_req_item)
//  segment   | empty / pop          | o_result (msplit_pkg::t_seg_item)
//
// A request is checked and queued in the cycle it is pushed; requests are
// taken every cycle while the request queue has room.
// The segment engine emits one result per cycle while the result queue has
// room; a request gives one to three results, and the next request is
// loaded in the same cycle as the last segment of the previous one.
// A result is built from the registers its request is loaded into.
// Reset clears queue counts, pointers and busy flag; no clearing pass.
// A stalled output fills the result queue, then the request queue, then full.
module mapping_range_page_splitter #(
    parameter int REQ_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  msplit_pkg::t_req_item i_item,
    output logic                  empty,
    input  logic                  pop,
    output msplit_pkg::t_seg_item o_result
);
    import msplit_pkg::*;

    t_req_entry front_entry;
    t_req_entry q_head;
    logic       q_empty;
    logic       q_pop;
    t_seg_item  seg;
    logic       seg_push;
    logic       seg_full;

    msplit_front u_front (
        .i_item  (i_item),
        .o_entry (front_entry)
    );

    msplit_fifo #(
        .T     (t_req_entry),
        .DEPTH (REQ_DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_head)
    );

    msplit_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_empty (q_empty),
        .i_req       (q_head),
        .o_req_pop   (q_pop),
        .i_seg_full  (seg_full),
        .o_seg_push  (seg_push),
        .o_seg       (seg)
    );

    msplit_fifo #(
        .T     (t_seg_item),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (seg_push),
        .i_data  (seg),
        .o_full  (seg_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );

endmodule
